[rtl/core/voxfc_pkg.sv]
`default_nettype none

package voxfc_pkg;

	// field widths
	localparam int COORD_W  = 5;
	localparam int COLOUR_W = 8;
	localparam int FLAG_W   = 6;
	localparam int SIZE_W   = 6;
	localparam int INDEX_W  = 2;

	// clamped grid extent, wide enough for the largest maximum dimension
	localparam int DIM_W = 9;

	// default maximum grid dimensions
	localparam int DEF_MAX_DIM_X = 32;
	localparam int DEF_MAX_DIM_Y = 32;
	localparam int DEF_MAX_DIM_Z = 32;

	// colour code of an empty voxel
	localparam logic [COLOUR_W-1:0] EMPTY_CODE = 8'hFF;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [INDEX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [INDEX_W-1:0] REG_SIZE_Z = 2'd2;

	// reset value of the size registers
	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

endpackage

`default_nettype wire

[rtl/core/voxfc_ram.sv]
`default_nettype none

module voxfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  wire logic                                       clk,
	input  wire logic                                       en,
	input  wire logic                                       we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                           wdata,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/voxel_face_cover_flags.sv]
`default_nettype none

// channel   | signals                                        | timing
// ----------+------------------------------------------------+------------------------------
// command   | start, busy, operation, coord_x/y/z, colour_in | taken when start & !busy
// result    | done, colour_out, face_flags, coord_error      | done high for one cycle
// config    | cfg_write, cfg_index, cfg_data                 | written on any cfg_write edge
//
// after reset the store is swept to empty, one entry per cycle:
// all MAX_DIM_X*MAX_DIM_Y*MAX_DIM_Z entries (32768 by default) with busy high.
// a write holds busy in the address and write states, a query in the address state, seven
// read steps on the single memory port and a capture state, with done in the next cycle.
// outside the grid either holds busy in the address state only, a query's done following
// in the next. results cannot be stalled; busy is the only back pressure.

module voxel_face_cover_flags #(
	parameter int MAX_DIM_X = voxfc_pkg::DEF_MAX_DIM_X,
	parameter int MAX_DIM_Y = voxfc_pkg::DEF_MAX_DIM_Y,
	parameter int MAX_DIM_Z = voxfc_pkg::DEF_MAX_DIM_Z
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [voxfc_pkg::INDEX_W-1:0]      cfg_index,
	input  wire logic [voxfc_pkg::SIZE_W-1:0]       cfg_data,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               operation,
	input  wire logic [voxfc_pkg::COORD_W-1:0]      coord_x,
	input  wire logic [voxfc_pkg::COORD_W-1:0]      coord_y,
	input  wire logic [voxfc_pkg::COORD_W-1:0]      coord_z,
	input  wire logic [voxfc_pkg::COLOUR_W-1:0]     colour_in,
	output logic                                    done,
	output logic      [voxfc_pkg::COLOUR_W-1:0]     colour_out,
	output logic      [voxfc_pkg::FLAG_W-1:0]       face_flags,
	output logic                                    coord_error
);

	import voxfc_pkg::*;

	localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	// address strides of one step along each axis
	localparam logic [AW-1:0] STRIDE_X  = AW'(MAX_DIM_Y * MAX_DIM_Z);
	localparam logic [AW-1:0] STRIDE_Y  = AW'(MAX_DIM_Z);
	localparam logic [AW-1:0] STRIDE_Z  = AW'(1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	localparam logic [DIM_W-1:0] LIM_X = DIM_W'(MAX_DIM_X);
	localparam logic [DIM_W-1:0] LIM_Y = DIM_W'(MAX_DIM_Y);
	localparam logic [DIM_W-1:0] LIM_Z = DIM_W'(MAX_DIM_Z);

	// read sequence: center voxel, then the six neighbours in flag order
	localparam logic [2:0] STEP_CENTER = 3'd0;
	localparam logic [2:0] STEP_WEST   = 3'd1;
	localparam logic [2:0] STEP_EAST   = 3'd2;
	localparam logic [2:0] STEP_SOUTH  = 3'd3;
	localparam logic [2:0] STEP_NORTH  = 3'd4;
	localparam logic [2:0] STEP_DOWN   = 3'd5;
	localparam logic [2:0] STEP_UP     = 3'd6;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_WRITE,
		ST_READ,
		ST_LAST
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [DIM_W-1:0]    ext_x, ext_y, ext_z;
	logic                in_grid;

	logic                op_q;
	logic                inside_q;
	logic [COORD_W-1:0]  cx_q, cy_q, cz_q;
	logic [COLOUR_W-1:0] colour_in_q;
	logic [AW-1:0]       base_q;
	logic [AW-1:0]       clr_addr_q;
	logic [2:0]          step_q;

	logic                cap_s1;
	logic                nb_valid_s1;
	logic [2:0]          step_s1;

	logic                done_q;
	logic                err_q;
	logic [COLOUR_W-1:0] colour_q;
	logic [FLAG_W-1:0]   flags_q;

	logic [AW-1:0]       base_d;
	logic [AW-1:0]       stride;
	logic                stride_sub;
	logic                nb_valid;
	logic [AW-1:0]       rd_addr;

	logic                ram_en;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [COLOUR_W-1:0] ram_wdata;
	logic [COLOUR_W-1:0] ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective grid extent, sizes above the maximum act as the maximum
	assign ext_x = (DIM_W'(size_x_q) > LIM_X) ? LIM_X : DIM_W'(size_x_q);
	assign ext_y = (DIM_W'(size_y_q) > LIM_Y) ? LIM_Y : DIM_W'(size_y_q);
	assign ext_z = (DIM_W'(size_z_q) > LIM_Z) ? LIM_Z : DIM_W'(size_z_q);

	assign in_grid = (DIM_W'(coord_x) < ext_x) && (DIM_W'(coord_y) < ext_y)
		&& (DIM_W'(coord_z) < ext_z);

	// linear address of the addressed voxel
	assign base_d = AW'((int'(cx_q) * MAX_DIM_Y + int'(cy_q)) * MAX_DIM_Z + int'(cz_q));

	// stride and neighbour bounds for the current read step
	always_comb begin
		stride     = '0;
		stride_sub = 1'b0;
		nb_valid   = 1'b0;
		unique case (step_q)
			STEP_CENTER: begin
				nb_valid = 1'b1;
			end
			STEP_WEST: begin
				stride     = STRIDE_X;
				stride_sub = 1'b1;
				nb_valid   = (cx_q != '0);
			end
			STEP_EAST: begin
				stride   = STRIDE_X;
				nb_valid = (DIM_W'(cx_q) + DIM_W'(1)) < ext_x;
			end
			STEP_SOUTH: begin
				stride     = STRIDE_Y;
				stride_sub = 1'b1;
				nb_valid   = (cy_q != '0);
			end
			STEP_NORTH: begin
				stride   = STRIDE_Y;
				nb_valid = (DIM_W'(cy_q) + DIM_W'(1)) < ext_y;
			end
			STEP_DOWN: begin
				stride     = STRIDE_Z;
				stride_sub = 1'b1;
				nb_valid   = (cz_q != '0);
			end
			STEP_UP: begin
				stride   = STRIDE_Z;
				nb_valid = (DIM_W'(cz_q) + DIM_W'(1)) < ext_z;
			end
			default: ;
		endcase
	end

	// shared address adder
	assign rd_addr = stride_sub ? (base_q - stride) : (base_q + stride);

	// memory port control
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = rd_addr;
		ram_wdata = colour_in_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = EMPTY_CODE;
			end
			ST_WRITE: begin
				ram_we   = 1'b1;
				ram_addr = base_q;
			end
			ST_READ: begin
				ram_en = nb_valid;
			end
			default: ;
		endcase
	end

	voxfc_ram #(
		.WIDTH (COLOUR_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// read capture pipeline, registered in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_s1 <= 1'b0;
		end else begin
			cap_s1 <= (state_q == ST_READ);
		end
	end

	always_ff @(posedge clk) begin
		nb_valid_s1 <= nb_valid;
		step_s1     <= step_q;
	end

	// command latch
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q        <= operation;
			inside_q    <= in_grid;
			cx_q        <= coord_x;
			cy_q        <= coord_y;
			cz_q        <= coord_z;
			colour_in_q <= colour_in;
		end
		if (state_q == ST_ADDR) begin
			base_q <= base_d;
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			step_q     <= '0;
			done_q     <= 1'b0;
			err_q      <= 1'b0;
			colour_q   <= '0;
			flags_q    <= '0;
		end else begin
			done_q <= 1'b0;

			// capture a returned read into the result
			if (cap_s1) begin
				if (step_s1 == STEP_CENTER) begin
					colour_q <= ram_rdata;
				end else begin
					flags_q[step_s1 - 3'd1] <= nb_valid_s1 && (ram_rdata != EMPTY_CODE);
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					step_q <= STEP_CENTER;
					if (op_q == OP_WRITE) begin
						state_q <= inside_q ? ST_WRITE : ST_IDLE;
					end else if (!inside_q) begin
						// query outside the grid
						colour_q <= '0;
						flags_q  <= '0;
						err_q    <= 1'b1;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						err_q   <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_UP) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign colour_out  = colour_q;
	assign face_flags  = flags_q;
	assign coord_error = err_q;

endmodule

`default_nettype wire
